>>> hdl/dsc_pkg.sv
// ----------------------------------------------------------------------------
// dsc_pkg: shared types and functions of the declaration syntax checker
// Word types, automaton state codes, keyword table and the automaton step.
// ----------------------------------------------------------------------------
`default_nettype none

package dsc_pkg;

  // longest identifier prefix kept for keyword matching
  localparam int unsigned KEYWORD_MAX_LEN = 8;
  localparam int unsigned KW_COUNT = 10;
  localparam int unsigned KW_TYPE_COUNT = 8;
  localparam int unsigned KW_BYTES = 8;

  // automaton states Q1..Q8 and final
  localparam logic [3:0] ST_Q1    = 4'd0;
  localparam logic [3:0] ST_Q2    = 4'd1;
  localparam logic [3:0] ST_Q3    = 4'd2;
  localparam logic [3:0] ST_Q4    = 4'd3;
  localparam logic [3:0] ST_Q5    = 4'd4;
  localparam logic [3:0] ST_Q6    = 4'd5;
  localparam logic [3:0] ST_Q7    = 4'd6;
  localparam logic [3:0] ST_Q8    = 4'd7;
  localparam logic [3:0] ST_FINAL = 4'd8;

  // characters with a meaning of their own
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = " ";
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR = "$";
  localparam logic [7:0] CH_DOT    = ".";
  localparam logic [7:0] CH_COMMA  = ",";
  localparam logic [7:0] CH_SEMI   = ";";
  localparam logic [7:0] CH_LBRACK = "[";
  localparam logic [7:0] CH_RBRACK = "]";
  localparam logic [7:0] CH_EQUAL  = "=";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_STAR   = "*";
  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_LESS   = "<";
  localparam logic [7:0] CH_GREATER = ">";

  // keywords, right aligned: first character in the highest used byte
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'("entero"), 64'("real"), 64'("caracter"), 64'("cadena"), 64'("bool"),
    64'("double"), 64'("long"), 64'("short"), 64'("true"), 64'("false")
  };
  localparam logic [4:0] KW_LEN [KW_COUNT] = '{
    5'd6, 5'd4, 5'd8, 5'd6, 5'd4, 5'd6, 5'd4, 5'd5, 5'd4, 5'd5
  };

  typedef enum logic [2:0] {
    TK_IDENT,
    TK_NUM,
    TK_STR_CLOSED,
    TK_STR_OPEN,
    TK_OP,
    TK_END,
    TK_NONE
  } tok_kind_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } dsc_in_t;

  typedef struct packed {
    logic       accepted;
    logic [3:0] final_state;
  } dsc_out_t;

  // automaton status
  typedef struct packed {
    logic [3:0] st;
    logic       rej;
    logic       stop;
  } dsc_chk_t;

  // tok holds byte j at bits [8j+7:8j]
  function automatic logic kw_match(input logic [63:0] tok, input logic [4:0] len,
                                    input int unsigned idx);
    logic hit;
    logic [4:0] pos;
    hit = (len == KW_LEN[idx]);
    for (int j = 0; j < KW_BYTES; j++) begin
      pos = KW_LEN[idx] - 5'(j) - 5'd1;
      if (5'(j) < KW_LEN[idx]) begin
        if (tok[8*j +: 8] != KW_TEXT[idx][8*pos[2:0] +: 8]) hit = 1'b0;
      end
    end
    return hit;
  endfunction

  // one token into the declaration automaton
  function automatic dsc_chk_t dsc_feed(input dsc_chk_t s, input tok_kind_e kind,
                                        input logic [7:0] op, input logic type_kw,
                                        input logic bool_kw, input logic dot_first,
                                        input logic len_one);
    dsc_chk_t   r;
    logic       ok;
    logic [3:0] nx;
    logic       is_op;
    logic       is_num;
    logic       is_id;
    logic       is_val;
    logic       is_type;
    r       = s;
    ok      = 1'b0;
    nx      = s.st;
    is_op   = (kind == TK_OP);
    is_num  = (kind == TK_NUM) && !(dot_first && len_one);
    is_id   = !(((kind == TK_NUM) && !dot_first) || is_op);
    is_val  = ((kind == TK_IDENT) && bool_kw) || is_num || (kind == TK_STR_CLOSED);
    is_type = (kind == TK_IDENT) && type_kw;
    if (!(s.rej || s.stop)) begin
      case (s.st)
        ST_Q1: begin
          if (is_type) begin nx = ST_Q2; ok = 1'b1; end
        end
        ST_Q2: begin
          if (is_id) begin nx = ST_Q3; ok = 1'b1; end
        end
        ST_Q3: begin
          if (is_op && op == CH_SEMI) begin nx = ST_Q4; ok = 1'b1; end
          else if (is_op && op == CH_COMMA) begin nx = ST_Q2; ok = 1'b1; end
          else if (is_op && op == CH_LBRACK) begin nx = ST_Q5; ok = 1'b1; end
          else if (is_op && op == CH_EQUAL) begin nx = ST_Q8; ok = 1'b1; end
        end
        ST_Q4: begin
          if (kind == TK_END) begin nx = ST_FINAL; ok = 1'b1; end
          else if (is_type) begin nx = ST_Q2; ok = 1'b1; end
        end
        ST_Q5: begin
          if (is_num) begin nx = ST_Q6; ok = 1'b1; end
        end
        ST_Q6: begin
          if (is_op && op == CH_RBRACK) begin nx = ST_Q7; ok = 1'b1; end
        end
        ST_Q7: begin
          if (is_op && op == CH_SEMI) begin nx = ST_Q4; ok = 1'b1; end
          else if (is_op && op == CH_COMMA) begin nx = ST_Q2; ok = 1'b1; end
        end
        ST_Q8: begin
          if (is_val) begin nx = ST_Q7; ok = 1'b1; end
        end
        default: ok = 1'b1;
      endcase
      if (ok) r.st = nx;
      else r.rej = 1'b1;
      if (kind == TK_END) r.stop = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/dsc_core.sv
// ----------------------------------------------------------------------------
// dsc_core: lexer and declaration automaton
// Consumes one word per step, keeps token and automaton state, and
// computes the verdict for an end-of-text word.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_core import dsc_pkg::*; #(
  parameter int unsigned KeywordMaxLen = KEYWORD_MAX_LEN
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      step_i,
  input  dsc_in_t  word_i,
  output dsc_out_t res_o
);

  localparam int unsigned LenW = $clog2(KeywordMaxLen + 2);

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_IDENT = 2'd1;
  localparam logic [1:0] MODE_NUM   = 2'd2;
  localparam logic [1:0] MODE_STR   = 2'd3;

  dsc_chk_t                       chk_q, chk_d;
  logic [1:0]                     mode_q, mode_d;
  logic [KeywordMaxLen-1:0][7:0]  tok_q, tok_d;
  logic [LenW-1:0]                len_q, len_d;
  logic                           dseen_q, dseen_d;
  logic                           dfirst_q, dfirst_d;

  logic [7:0]  c;
  logic        is_lower, is_digit, is_opch;
  logic        type_kw, bool_kw, len_one;
  logic [63:0] tok_lo;
  logic [4:0]  len5;
  logic        go;

  assign tok_lo  = tok_q[KW_BYTES-1:0];
  assign len5    = 5'(len_q);
  assign len_one = (len_q == LenW'(1));

  always_comb begin
    type_kw = 1'b0;
    for (int unsigned i = 0; i < KW_TYPE_COUNT; i++) begin
      if (kw_match(tok_lo, len5, i)) type_kw = 1'b1;
    end
    bool_kw = kw_match(tok_lo, len5, 8) || kw_match(tok_lo, len5, 9);
  end

  always_comb begin
    c = word_i.ch;
    if (c == CH_TAB || c == CH_LF || c == CH_CR) c = CH_SPACE;
    is_lower = (c >= "a") && (c <= "z");
    is_digit = (c >= "0") && (c <= "9");
    is_opch  = (c == CH_COMMA) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
               (c == CH_EQUAL) || (c == CH_STAR) || (c == CH_SLASH) ||
               (c == CH_MINUS) || (c == CH_PLUS) || (c == CH_LESS) ||
               (c == CH_GREATER) || (c == CH_SEMI) || (c == CH_LBRACK) ||
               (c == CH_RBRACK);
  end

  always_comb begin
    chk_d    = chk_q;
    mode_d   = mode_q;
    tok_d    = tok_q;
    len_d    = len_q;
    dseen_d  = dseen_q;
    dfirst_d = dfirst_q;
    res_o    = '0;
    go       = 1'b0;
    if (step_i) begin
      if (word_i.end_of_text) begin
        // flush pending token, then the end token
        case (mode_q)
          MODE_IDENT: chk_d = dsc_feed(chk_d, TK_IDENT, c, type_kw, bool_kw,
                                       dfirst_q, len_one);
          MODE_NUM:   chk_d = dsc_feed(chk_d, TK_NUM, c, type_kw, bool_kw,
                                       dfirst_q, len_one);
          MODE_STR:   chk_d = dsc_feed(chk_d, TK_STR_OPEN, c, type_kw, bool_kw,
                                       dfirst_q, len_one);
          default:    ;
        endcase
        chk_d             = dsc_feed(chk_d, TK_END, c, type_kw, bool_kw,
                                     dfirst_q, len_one);
        res_o.accepted    = (chk_d.st == ST_FINAL) && !chk_d.rej;
        res_o.final_state = chk_d.st;
        chk_d    = '0;
        mode_d   = MODE_IDLE;
        tok_d    = '0;
        len_d    = '0;
        dseen_d  = 1'b0;
        dfirst_d = 1'b0;
      end else begin
        case (mode_q)
          MODE_STR: begin
            if (c == CH_QUOTE) begin
              chk_d  = dsc_feed(chk_d, TK_STR_CLOSED, c, type_kw, bool_kw,
                                dfirst_q, len_one);
              mode_d = MODE_IDLE;
              tok_d  = '0;
              len_d  = '0;
            end
          end
          MODE_IDENT, MODE_NUM: begin
            if (is_digit || (mode_q == MODE_IDENT && is_lower) ||
                (mode_q == MODE_NUM && c == CH_DOT && !dseen_q)) begin
              if (c == CH_DOT) dseen_d = 1'b1;
              for (int unsigned i = 0; i < KeywordMaxLen; i++) begin
                if (len_q == LenW'(i)) tok_d[i] = c;
              end
              if (len_q <= LenW'(KeywordMaxLen)) len_d = len_q + LenW'(1);
            end else begin
              chk_d    = dsc_feed(chk_d, (mode_q == MODE_IDENT) ? TK_IDENT : TK_NUM,
                                  c, type_kw, bool_kw, dfirst_q, len_one);
              mode_d   = MODE_IDLE;
              tok_d    = '0;
              len_d    = '0;
              dseen_d  = 1'b0;
              dfirst_d = 1'b0;
              go       = 1'b1;
            end
          end
          default: go = 1'b1;
        endcase
        if (go) begin
          if (c == CH_SPACE) begin
            // separator
          end else if (c == CH_QUOTE) begin
            mode_d = MODE_STR;
          end else if (is_lower) begin
            mode_d   = MODE_IDENT;
            tok_d[0] = c;
            len_d    = LenW'(1);
          end else if (is_digit || c == CH_DOT) begin
            mode_d   = MODE_NUM;
            dfirst_d = (c == CH_DOT);
            dseen_d  = (c == CH_DOT);
            tok_d[0] = c;
            len_d    = LenW'(1);
          end else if (is_opch) begin
            chk_d = dsc_feed(chk_d, TK_OP, c, type_kw, bool_kw, dfirst_q, len_one);
          end else if (c == CH_DOLLAR) begin
            chk_d = dsc_feed(chk_d, TK_END, c, type_kw, bool_kw, dfirst_q, len_one);
          end else begin
            // unknown byte: empty token checked twice
            chk_d = dsc_feed(chk_d, TK_NONE, c, type_kw, bool_kw, dfirst_q, len_one);
            chk_d = dsc_feed(chk_d, TK_NONE, c, type_kw, bool_kw, dfirst_q, len_one);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q    <= '0;
      mode_q   <= MODE_IDLE;
      tok_q    <= '0;
      len_q    <= '0;
      dseen_q  <= 1'b0;
      dfirst_q <= 1'b0;
    end else begin
      chk_q    <= chk_d;
      mode_q   <= mode_d;
      tok_q    <= tok_d;
      len_q    <= len_d;
      dseen_q  <= dseen_d;
      dfirst_q <= dfirst_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/declaration_syntax_checker.sv
// ----------------------------------------------------------------------------
// declaration_syntax_checker: top level
// Lexes source text a byte per word and checks type declarations, giving
// one verdict word for each end-of-text word.
//
//   channel  | signals                          | word
//   ---------+----------------------------------+-------------------------
//   in       | in_valid_i in_ready_o in_word_i  | ch, end_of_text
//   out      | out_valid_o out_ready_i out_word_o | accepted, final_state
//
// one input word is taken per cycle while in_ready_o is high; lexer and
// automaton update in the cycle the word is accepted, through a single
// register stage; an end-of-text word produces its verdict in the output
// register in the cycle after acceptance; other words produce nothing
// in_ready_o drops only while a verdict sits unread and out_ready_i is low
// reset clears the automaton, the token buffer and the output valid
// ----------------------------------------------------------------------------
`default_nettype none

module declaration_syntax_checker import dsc_pkg::*; #(
  parameter int unsigned KeywordMaxLen = KEYWORD_MAX_LEN
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      in_valid_i,
  output logic     in_ready_o,
  input  dsc_in_t  in_word_i,
  output logic     out_valid_o,
  input  wire      out_ready_i,
  output dsc_out_t out_word_o
);

  logic     in_fire;
  dsc_out_t res;
  logic     out_valid_q, out_valid_d;
  dsc_out_t out_q;

  // take a word unless the verdict register is full and stalled
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // lexer plus automaton
  dsc_core #(
    .KeywordMaxLen(KeywordMaxLen)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(in_fire),
    .word_i(in_word_i),
    .res_o (res)
  );

  // verdict register: loads on an accepted end word, drains on out handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (in_fire && in_word_i.end_of_text) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_fire && in_word_i.end_of_text) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // a fresh verdict always follows an accepted end word
  a_verdict_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |->
      $past(in_valid_i && in_ready_o && in_word_i.end_of_text))
    else $error("verdict without end word");

  // acceptance only in the final state
  a_accept_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.accepted) |-> (out_word_o.final_state == ST_FINAL))
    else $error("accepted outside final state");

  // reported state is in range
  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.final_state <= ST_FINAL))
    else $error("final state out of range");

  // input stalls only behind an unread verdict
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");

endmodule

`default_nettype wire

>>> verif/tb_declaration_syntax_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_declaration_syntax_checker: self-checking testbench of the syntax checker
// Streams source text one character word at a time, closes each text with an
// end word and checks every verdict word against a predictor in the bench.
// A short directed table comes first, then random declaration texts, some
// damaged and some pure noise, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------

module tb_declaration_syntax_checker;
  import dsc_pkg::*;

  localparam int unsigned RANDOM_WORDS  = 700;
  localparam int unsigned MAX_SHOWN     = 10;
  localparam int unsigned DRAIN_CYCLES  = 10;
  localparam int unsigned DIRECTED_ROWS = 22;
  // indexes of the two value keywords behind the eight type keywords
  localparam int unsigned WORD_TRUE     = 8;
  localparam int unsigned WORD_FALSE    = 9;

  // lexer modes of the predictor
  typedef enum logic [1:0] {
    LX_GAP,
    LX_WORD,
    LX_NUM,
    LX_STR
  } lex_mode_e;

  // one row of the directed table: the word, and a verdict typed in by hand
  typedef struct packed {
    dsc_in_t  w;
    logic     known;
    dsc_out_t verdict;
  } plan_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  dsc_in_t  in_word;
  logic     out_valid;
  logic     out_ready;
  dsc_out_t out_word;

  declaration_syntax_checker uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // --------------------------------------------------------------------------
  // predictor: automaton status plus lexer state
  // --------------------------------------------------------------------------
  logic [3:0] decl_st;
  logic       decl_rej;
  logic       decl_stop;
  lex_mode_e  lex_mode;
  logic [7:0] lex_buf [KEYWORD_MAX_LEN];
  int unsigned lex_len;
  logic       lex_dot;
  logic       lex_dot_lead;

  // verdicts still owed by the block, oldest first
  dsc_out_t   verdict_q [$];

  function automatic string keyword_text(input int unsigned idx);
    string s;
    case (idx)
      0:       s = "entero";
      1:       s = "real";
      2:       s = "caracter";
      3:       s = "cadena";
      4:       s = "bool";
      5:       s = "double";
      6:       s = "long";
      7:       s = "short";
      8:       s = "true";
      default: s = "false";
    endcase
    return s;
  endfunction

  // held identifier equals keyword idx; an overlong one never matches
  function automatic logic lexeme_is(input int unsigned idx);
    string w;
    w = keyword_text(idx);
    if (lex_len != w.len()) return 1'b0;
    for (int i = 0; i < w.len(); i++) begin
      if (lex_buf[i] != w[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return c >= "a" && c <= "z";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_op_char(input logic [7:0] c);
    return c == CH_COMMA || c == CH_LPAREN || c == CH_RPAREN || c == CH_EQUAL ||
           c == CH_STAR || c == CH_SLASH || c == CH_MINUS || c == CH_PLUS ||
           c == CH_LESS || c == CH_GREATER || c == CH_SEMI || c == CH_LBRACK ||
           c == CH_RBRACK;
  endfunction

  // one token into the declaration automaton
  function automatic void decl_advance(input tok_kind_e kind, input logic [7:0] op);
    logic       ok;
    logic [3:0] nx;
    logic       is_op;
    logic       is_type;
    logic       is_num;
    logic       is_id;
    logic       is_val;
    if (decl_rej || decl_stop) return;
    ok      = 1'b0;
    nx      = decl_st;
    is_op   = (kind == TK_OP);
    is_type = 1'b0;
    if (kind == TK_IDENT) begin
      for (int i = 0; i < KW_TYPE_COUNT; i++) begin
        if (lexeme_is(i)) is_type = 1'b1;
      end
    end
    // a lone dot is a number token but not a number
    is_num = (kind == TK_NUM) && !(lex_dot_lead && lex_len == 1);
    // loose test: anything but a digit-led number or an operator
    is_id  = !((kind == TK_NUM && !lex_dot_lead) || is_op);
    is_val = (kind == TK_IDENT && (lexeme_is(WORD_TRUE) || lexeme_is(WORD_FALSE))) ||
             is_num || kind == TK_STR_CLOSED;
    case (decl_st)
      ST_Q1: begin
        if (is_type) begin nx = ST_Q2; ok = 1'b1; end
      end
      ST_Q2: begin
        if (is_id) begin nx = ST_Q3; ok = 1'b1; end
      end
      ST_Q3: begin
        if (is_op && op == CH_SEMI) begin nx = ST_Q4; ok = 1'b1; end
        else if (is_op && op == CH_COMMA) begin nx = ST_Q2; ok = 1'b1; end
        else if (is_op && op == CH_LBRACK) begin nx = ST_Q5; ok = 1'b1; end
        else if (is_op && op == CH_EQUAL) begin nx = ST_Q8; ok = 1'b1; end
      end
      ST_Q4: begin
        if (kind == TK_END) begin nx = ST_FINAL; ok = 1'b1; end
        else if (is_type) begin nx = ST_Q2; ok = 1'b1; end
      end
      ST_Q5: begin
        if (is_num) begin nx = ST_Q6; ok = 1'b1; end
      end
      ST_Q6: begin
        if (is_op && op == CH_RBRACK) begin nx = ST_Q7; ok = 1'b1; end
      end
      ST_Q7: begin
        if (is_op && op == CH_SEMI) begin nx = ST_Q4; ok = 1'b1; end
        else if (is_op && op == CH_COMMA) begin nx = ST_Q2; ok = 1'b1; end
      end
      ST_Q8: begin
        if (is_val) begin nx = ST_Q7; ok = 1'b1; end
      end
      default: ok = 1'b1;
    endcase
    if (ok) decl_st = nx;
    else decl_rej = 1'b1;
    if (kind == TK_END) decl_stop = 1'b1;
  endfunction

  function automatic void clear_lexeme();
    lex_mode     = LX_GAP;
    lex_len      = 0;
    lex_dot      = 1'b0;
    lex_dot_lead = 1'b0;
    foreach (lex_buf[i]) lex_buf[i] = 8'h00;
  endfunction

  // keep the first bytes for keyword matching, length saturates one past
  function automatic void lex_take(input logic [7:0] c);
    if (lex_len < KEYWORD_MAX_LEN) lex_buf[lex_len] = c;
    if (lex_len <= KEYWORD_MAX_LEN) lex_len++;
  endfunction

  function automatic void close_lexeme();
    case (lex_mode)
      LX_WORD: decl_advance(TK_IDENT, 8'h00);
      LX_NUM:  decl_advance(TK_NUM, 8'h00);
      LX_STR:  decl_advance(TK_STR_OPEN, 8'h00);
      default: ;
    endcase
    clear_lexeme();
  endfunction

  function automatic void reset_checker();
    decl_st   = ST_Q1;
    decl_rej  = 1'b0;
    decl_stop = 1'b0;
    clear_lexeme();
  endfunction

  // advance the predictor by one accepted word; has is set on an end word
  function automatic void predict_verdict(input dsc_in_t w, output logic has,
                                          output dsc_out_t r);
    logic [7:0] c;
    has = 1'b0;
    r   = '0;
    c   = w.ch;
    if (w.end_of_text) begin
      // pending token first, then the end token unless checking stopped
      close_lexeme();
      decl_advance(TK_END, 8'h00);
      r.accepted    = (decl_st == ST_FINAL) && !decl_rej;
      r.final_state = decl_st;
      has = 1'b1;
      reset_checker();
      return;
    end
    if (c == CH_TAB || c == CH_LF || c == CH_CR) c = CH_SPACE;
    // inside a string everything up to the closing quote is content
    if (lex_mode == LX_STR) begin
      if (c == CH_QUOTE) begin
        decl_advance(TK_STR_CLOSED, 8'h00);
        clear_lexeme();
      end
      return;
    end
    if (lex_mode == LX_WORD) begin
      if (is_lower(c) || is_digit(c)) begin
        lex_take(c);
        return;
      end
      close_lexeme();
    end else if (lex_mode == LX_NUM) begin
      if (is_digit(c)) begin
        lex_take(c);
        return;
      end
      if (c == CH_DOT && !lex_dot) begin
        lex_dot = 1'b1;
        lex_take(c);
        return;
      end
      close_lexeme();
    end
    if (c == CH_SPACE) begin
      // separator only
    end else if (c == CH_QUOTE) begin
      lex_mode = LX_STR;
    end else if (is_lower(c)) begin
      lex_mode = LX_WORD;
      lex_take(c);
    end else if (is_digit(c) || c == CH_DOT) begin
      lex_mode     = LX_NUM;
      lex_dot_lead = (c == CH_DOT);
      lex_dot      = lex_dot_lead;
      lex_take(c);
    end else if (is_op_char(c)) begin
      decl_advance(TK_OP, c);
    end else if (c == CH_DOLLAR) begin
      decl_advance(TK_END, 8'h00);
    end else begin
      // unknown byte: the empty token is seen twice, rejecting at the latest in Q3
      decl_advance(TK_NONE, 8'h00);
      decl_advance(TK_NONE, 8'h00);
    end
  endfunction

  // --------------------------------------------------------------------------
  // directed table: extremes, tab as blank, dollar end, unknown byte, open string
  // --------------------------------------------------------------------------
  plan_row_t directed_plan [DIRECTED_ROWS] = '{
    // end word straight after reset: Q1 sees the end token and rejects
    '{'{8'hA5, 1'b1}, 1'b1, '{1'b0, ST_Q1}},
    // "bool<tab>a;$" is a full declaration, the end word adds nothing
    '{'{"b", 1'b0}, 1'b0, '0},
    '{'{"o", 1'b0}, 1'b0, '0},
    '{'{"o", 1'b0}, 1'b0, '0},
    '{'{"l", 1'b0}, 1'b0, '0},
    '{'{CH_TAB, 1'b0}, 1'b0, '0},
    '{'{"a", 1'b0}, 1'b0, '0},
    '{'{CH_SEMI, 1'b0}, 1'b0, '0},
    '{'{CH_DOLLAR, 1'b0}, 1'b0, '0},
    '{'{8'h5A, 1'b1}, 1'b1, '{1'b1, ST_FINAL}},
    // byte 0xff is unknown and rejects in Q1
    '{'{8'hFF, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b1}, 1'b1, '{1'b0, ST_Q1}},
    // "short x=" then a string left open at the end word: not a value
    '{'{"s", 1'b0}, 1'b0, '0},
    '{'{"h", 1'b0}, 1'b0, '0},
    '{'{"o", 1'b0}, 1'b0, '0},
    '{'{"r", 1'b0}, 1'b0, '0},
    '{'{"t", 1'b0}, 1'b0, '0},
    '{'{CH_SPACE, 1'b0}, 1'b0, '0},
    '{'{"x", 1'b0}, 1'b0, '0},
    '{'{CH_EQUAL, 1'b0}, 1'b0, '0},
    '{'{CH_QUOTE, 1'b0}, 1'b0, '0},
    '{'{8'hFF, 1'b1}, 1'b1, '{1'b0, ST_Q8}}
  };

  // --------------------------------------------------------------------------
  // random text builder
  // --------------------------------------------------------------------------
  logic [7:0] text_q [$];
  bit         last_was_op;
  bit         calm;          // no gaps and no stalls while set

  // gap or stall length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0:       return CH_TAB;
      1:       return CH_LF;
      2:       return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 12))
      0:       return CH_COMMA;
      1:       return CH_LPAREN;
      2:       return CH_RPAREN;
      3:       return CH_EQUAL;
      4:       return CH_STAR;
      5:       return CH_SLASH;
      6:       return CH_MINUS;
      7:       return CH_PLUS;
      8:       return CH_LESS;
      9:       return CH_GREATER;
      10:      return CH_SEMI;
      11:      return CH_LBRACK;
      default: return CH_RBRACK;
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0, 1:    return 8'($urandom_range(0, 255));
      2:       return 8'("a" + $urandom_range(0, 25));
      3:       return 8'("0" + $urandom_range(0, 9));
      4:       return pick_op();
      5: begin
        case ($urandom_range(0, 2))
          0:       return CH_DOT;
          1:       return CH_QUOTE;
          default: return CH_DOLLAR;
        endcase
      end
      default: return pick_blank();
    endcase
  endfunction

  // blanks before a token; two non-operator tokens always get one
  function automatic void token_gap(input bit is_op);
    int unsigned n;
    n = 0;
    if (text_q.size() != 0) begin
      if (is_op || last_was_op) n = ($urandom_range(0, 2) == 0) ? 1 : 0;
      else n = $urandom_range(1, 2);
    end
    repeat (n) text_q.push_back(pick_blank());
    last_was_op = is_op;
  endfunction

  function automatic void put_keyword(input int unsigned idx);
    string w;
    w = keyword_text(idx);
    token_gap(1'b0);
    for (int i = 0; i < w.len(); i++) text_q.push_back(w[i]);
  endfunction

  function automatic void put_op(input logic [7:0] c);
    token_gap(1'b1);
    text_q.push_back(c);
  endfunction

  function automatic void put_digits(input int unsigned n);
    repeat (n) text_q.push_back(8'("0" + $urandom_range(0, 9)));
  endfunction

  // names run past the kept prefix now and then
  function automatic void put_name();
    int unsigned n;
    int unsigned r;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 4);
    token_gap(1'b0);
    text_q.push_back(8'("a" + $urandom_range(0, 25)));
    repeat (n - 1) begin
      r = $urandom_range(0, 35);
      text_q.push_back((r < 26) ? 8'("a" + r) : 8'("0" + r - 26));
    end
  endfunction

  function automatic void put_number();
    token_gap(1'b0);
    case ($urandom_range(0, 15))
      0, 1, 2: begin put_digits($urandom_range(1, 2)); text_q.push_back(CH_DOT);
                     put_digits($urandom_range(1, 2)); end
      3: begin text_q.push_back(CH_DOT); put_digits($urandom_range(1, 2)); end
      4: begin put_digits(1); text_q.push_back(CH_DOT); end
      5: text_q.push_back(CH_DOT);
      // second dot starts a new number token
      6: begin put_digits(1); text_q.push_back(CH_DOT); put_digits(1);
               text_q.push_back(CH_DOT); put_digits(1); end
      default: put_digits($urandom_range(1, 3));
    endcase
  endfunction

  function automatic void put_string();
    logic [7:0] c;
    token_gap(1'b0);
    text_q.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 4)) begin
      c = 8'($urandom_range(32, 126));
      text_q.push_back((c == CH_QUOTE) ? CH_SPACE : c);
    end
    text_q.push_back(CH_QUOTE);
  endfunction

  // identifier slot: keywords, strings and dot-led numbers pass there too
  function automatic void put_ident();
    case ($urandom_range(0, 19))
      0: put_keyword($urandom_range(0, WORD_FALSE));
      1: put_string();
      2: begin
        token_gap(1'b0);
        text_q.push_back(CH_DOT);
        put_digits($urandom_range(1, 2));
      end
      default: put_name();
    endcase
  endfunction

  function automatic void put_value();
    case ($urandom_range(0, 3))
      0:       put_keyword($urandom_range(0, 1) ? WORD_TRUE : WORD_FALSE);
      1:       put_number();
      2:       put_string();
      default: put_name();
    endcase
  endfunction

  function automatic void build_text();
    int unsigned n_decl;
    int unsigned n_item;
    int unsigned pos;
    text_q.delete();
    last_was_op = 1'b0;
    // some texts are plain noise
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 12)) text_q.push_back(noise_byte());
      return;
    end
    n_decl = ($urandom_range(0, 5) == 0) ? 3 : $urandom_range(1, 2);
    for (int d = 0; d < n_decl; d++) begin
      put_keyword($urandom_range(0, KW_TYPE_COUNT - 1));
      n_item = $urandom_range(1, 3);
      for (int k = 0; k < n_item; k++) begin
        put_ident();
        case ($urandom_range(0, 3))
          0: begin put_op(CH_LBRACK); put_number(); put_op(CH_RBRACK); end
          1: begin put_op(CH_EQUAL); put_value(); end
          default: ;
        endcase
        if (k + 1 < n_item) put_op(CH_COMMA);
      end
      put_op(CH_SEMI);
    end
    // damage a share so that every state sees a wrong token
    if ($urandom_range(0, 9) < 3) begin
      pos = $urandom_range(0, text_q.size() - 1);
      case ($urandom_range(0, 2))
        0: text_q[pos] = noise_byte();
        1: while (text_q.size() > pos) void'(text_q.pop_back());
        default: text_q.insert(pos, pick_op());
      endcase
    end
    // dollar ends checking early, anything after it is ignored
    if ($urandom_range(0, 3) == 0) begin
      text_q.push_back(CH_DOLLAR);
      repeat ($urandom_range(0, 3)) text_q.push_back(noise_byte());
    end
  endfunction

  // --------------------------------------------------------------------------
  // input side: one word per call, valid held until the handshake
  // --------------------------------------------------------------------------
  int unsigned words_sent;
  int unsigned texts_sent;

  task automatic send_word(input dsc_in_t w, input logic known, input dsc_out_t fixed);
    int unsigned gap;
    logic        has;
    dsc_out_t    v;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // accepted at this edge
    words_sent++;
    if (w.end_of_text) texts_sent++;
    predict_verdict(w, has, v);
    if (has) verdict_q.push_back(known ? fixed : v);
  endtask

  // --------------------------------------------------------------------------
  // output side: random stalls, and the verdict check
  // --------------------------------------------------------------------------
  int unsigned verdicts_checked;
  int unsigned verdicts_accepting;
  int unsigned bad_verdicts;

  initial begin : ready_gen
    int unsigned hold;
    hold = 0;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : verdict_check
    dsc_out_t want;
    if (out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        bad_verdicts++;
        if (bad_verdicts <= MAX_SHOWN)
          $display("unexpected verdict word: accepted=%0b state=%0d",
                   out_word.accepted, out_word.final_state);
      end else begin
        want = verdict_q.pop_front();
        verdicts_checked++;
        if (out_word.accepted) verdicts_accepting++;
        if (out_word.accepted !== want.accepted ||
            out_word.final_state !== want.final_state) begin
          bad_verdicts++;
          if (bad_verdicts <= MAX_SHOWN)
            $display({"verdict %0d mismatch: expected accepted=%0b state=%0d, ",
                      "got accepted=%0b state=%0d"},
                     verdicts_checked, want.accepted, want.final_state,
                     out_word.accepted, out_word.final_state);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    dsc_in_t w;
    words_sent         = 0;
    texts_sent         = 0;
    verdicts_checked   = 0;
    verdicts_accepting = 0;
    bad_verdicts       = 0;
    calm               = 1'b0;
    in_valid <= 1'b0;
    in_word  <= '0;
    rst_n    <= 1'b0;
    reset_checker();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table first
    foreach (directed_plan[i])
      send_word(directed_plan[i].w, directed_plan[i].known, directed_plan[i].verdict);

    // random texts, each closed by an end word carrying a random byte
    while (words_sent < DIRECTED_ROWS + RANDOM_WORDS) begin
      build_text();
      calm = ($urandom_range(0, 4) == 0);
      foreach (text_q[i]) begin
        w.ch          = text_q[i];
        w.end_of_text = 1'b0;
        send_word(w, 1'b0, '0);
      end
      w.ch          = 8'($urandom_range(0, 255));
      w.end_of_text = 1'b1;
      send_word(w, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // let the last verdict out, then watch for strays
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d words in %0d texts, directed and random, with gaps and stalls",
             words_sent, texts_sent);
    $display("%0d verdicts checked, %0d accepting, %0d bad", verdicts_checked,
             verdicts_accepting, bad_verdicts);
    if (bad_verdicts == 0 && verdict_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
